[rtl/hacd_pkg.sv]
// hacd_pkg: shared types, constants and palette functions for the
// hi-res artifact colour decoder; no dependencies
package hacd_pkg;

    // line geometry
    localparam int LINE_BYTES      = 40;
    localparam int PIXELS_PER_BYTE = 7;
    localparam logic [6:0] LINE_BYTES_W  = 7'(LINE_BYTES);
    localparam logic [5:0] LAST_COL      = 6'(LINE_BYTES - 1);
    localparam logic [8:0] LAST_X        = 9'(LINE_BYTES * PIXELS_PER_BYTE - 1);
    localparam logic [2:0] LAST_IDX      = 3'(PIXELS_PER_BYTE - 1);
    localparam int COLOR_SET_BIT   = 7;

    // colour codes
    typedef enum logic [2:0] {
        COL_BLACK  = 3'd0,
        COL_GREEN  = 3'd1,
        COL_VIOLET = 3'd2,
        COL_WHITE  = 3'd3,
        COL_BLUE   = 3'd4,
        COL_ORANGE = 3'd5
    } color_t;

    // one byte waiting to be shown, with its neighbours at the byte edges
    typedef struct packed {
        logic [7:0] pix_byte;
        logic [8:0] base_x;
        logic       left;
        logic       right;
    } desc_t;

    // up to two bytes released by one input item
    typedef struct packed {
        logic  a_valid;
        desc_t a;
        logic  b_valid;
        desc_t b;
    } job_t;

    // first pixel position of a column
    function automatic logic [8:0] base_x_of(input logic [5:0] col);
        logic [8:0] c;
        c = {3'b000, col};
        return (c << 3) - c;
    endfunction

    // colour of one pixel from its own bit, its neighbours, the colour-set bit and x parity
    function automatic color_t color_of(input logic lit, input logic nbr,
                                        input logic set, input logic odd);
        color_t c;
        if (!lit)
            c = COL_BLACK;
        else if (nbr)
            c = COL_WHITE;
        else if (odd)
            c = set ? COL_ORANGE : COL_GREEN;
        else
            c = set ? COL_BLUE : COL_VIOLET;
        return c;
    endfunction

    // fixed palette, red in the top byte
    function automatic logic [23:0] rgb_of(input color_t c);
        logic [23:0] v;
        unique case (c)
            COL_BLACK:  v = {8'd0,   8'd0,   8'd0};
            COL_GREEN:  v = {8'd0,   8'd200, 8'd0};
            COL_VIOLET: v = {8'd160, 8'd0,   8'd255};
            COL_WHITE:  v = {8'd255, 8'd255, 8'd255};
            COL_BLUE:   v = {8'd0,   8'd128, 8'd255};
            COL_ORANGE: v = {8'd255, 8'd80,  8'd0};
            default:    v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/hacd_line_ctl.sv]
// hacd_line_ctl: scanline state (held byte, column, left neighbour) and
// the byte descriptors released by each accepted item; uses hacd_pkg
module hacd_line_ctl
    import hacd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [5:0] column,
    input  logic [7:0] data_byte,
    output job_t       job
);

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg,  held_byte_next;
    logic [5:0] held_col_reg,   held_col_next;
    logic       left_nb_reg,    left_nb_next;

    logic in_line;
    logic left_mid;

    // decode the column and build the job
    always_comb
    begin
        in_line  = {1'b0, column} < LINE_BYTES_W;
        left_mid = held_valid_reg ? held_byte_reg[6] : left_nb_reg;

        job.a_valid    = 1'b0;
        job.a.pix_byte = held_byte_reg;
        job.a.base_x   = base_x_of(held_col_reg);
        job.a.left     = left_nb_reg;
        job.a.right    = data_byte[0];
        job.b_valid    = 1'b0;
        job.b.pix_byte = data_byte;
        job.b.base_x   = base_x_of(column);
        job.b.left     = left_mid;
        job.b.right    = 1'b0;

        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        held_col_next   = held_col_reg;
        left_nb_next    = left_nb_reg;

        if (in_line) begin
            if (column == 6'd0) begin
                // new line: drop whatever was held
                held_valid_next = 1'b1;
                held_byte_next  = data_byte;
                held_col_next   = 6'd0;
                left_nb_next    = 1'b0;
            end else begin
                job.a_valid = held_valid_reg;
                if (column == LAST_COL) begin
                    // last column flushes both bytes
                    job.b_valid     = 1'b1;
                    held_valid_next = 1'b0;
                    held_byte_next  = 8'd0;
                    held_col_next   = 6'd0;
                    left_nb_next    = 1'b0;
                end else begin
                    held_valid_next = 1'b1;
                    held_byte_next  = data_byte;
                    held_col_next   = column;
                    left_nb_next    = left_mid;
                end
            end
        end

        if (!accept) begin
            job.a_valid = 1'b0;
            job.b_valid = 1'b0;
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'd0;
            held_col_reg   <= 6'd0;
            left_nb_reg    <= 1'b0;
        end else if (accept) begin
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            held_col_reg   <= held_col_next;
            left_nb_reg    <= left_nb_next;
        end
    end

endmodule

[rtl/hacd_emitter.sv]
// hacd_emitter: walks the released bytes one pixel per cycle while the output is not
// stalled, colours each pixel and holds it in the output register; uses hacd_pkg
module hacd_emitter
    import hacd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    output logic        job_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [8:0]  pixel_x,
    output color_t      color_code,
    output logic [23:0] rgb,
    output logic        run_last,
    output logic        line_end
);

    logic       job_valid_reg;
    desc_t      cur_reg;
    logic       pend_valid_reg;
    desc_t      pend_reg;
    logic [2:0] idx_reg;

    logic       out_valid_reg;
    logic [8:0] pixel_x_reg;
    color_t     color_reg;
    logic [23:0] rgb_reg;
    logic       run_last_reg;
    logic       line_end_reg;

    logic       adv;
    logic       step;
    logic       final_pix;
    logic [8:0] ext;
    logic [8:0] win;
    logic [8:0] x_now;
    color_t     code_now;

    // pixel colouring for the current position
    always_comb
    begin
        adv       = !out_valid_reg || out_ready;
        step      = adv && job_valid_reg;
        final_pix = (idx_reg == LAST_IDX) && !pend_valid_reg;
        job_ready = !job_valid_reg || (step && final_pix);
        ext       = {cur_reg.right, cur_reg.pix_byte[6:0], cur_reg.left};
        win       = ext >> idx_reg;
        x_now     = cur_reg.base_x + {6'd0, idx_reg};
        code_now  = color_of(win[1], win[0] | win[2],
                             cur_reg.pix_byte[COLOR_SET_BIT], x_now[0]);
    end

    // byte sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
        end else if (job_ready && (job.a_valid || job.b_valid)) begin
            job_valid_reg  <= 1'b1;
            pend_valid_reg <= job.a_valid && job.b_valid;
            idx_reg        <= 3'd0;
        end else if (step) begin
            if (idx_reg == LAST_IDX) begin
                idx_reg <= 3'd0;
                if (pend_valid_reg) begin
                    pend_valid_reg <= 1'b0;
                end else begin
                    job_valid_reg <= 1'b0;
                end
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // descriptor payload
    always_ff @(posedge clk)
    begin
        if (step && (idx_reg == LAST_IDX) && pend_valid_reg) begin
            cur_reg <= pend_reg;
        end
        if (job_ready && (job.a_valid || job.b_valid)) begin
            cur_reg  <= job.a_valid ? job.a : job.b;
            pend_reg <= job.b;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= job_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step) begin
            pixel_x_reg  <= x_now;
            color_reg    <= code_now;
            rgb_reg      <= rgb_of(code_now);
            run_last_reg <= final_pix;
            line_end_reg <= x_now == LAST_X;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign color_code = color_reg;
    assign rgb        = rgb_reg;
    assign run_last   = run_last_reg;
    assign line_end   = line_end_reg;

    // checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (idx_reg <= LAST_IDX))
        else $error("pixel index past end of byte");

    a_pend_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> job_valid_reg)
        else $error("second byte pending without a job");

    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_end_reg) |-> run_last_reg)
        else $error("line end pixel not last of its item");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (step && final_pix && !(job.a_valid || job.b_valid)) |=> !job_valid_reg)
        else $error("job still active after its final pixel");

endmodule

[rtl/hires_artifact_color_decoder.sv]
// Hi-res artifact colour decoder: display bytes in, one coloured pixel per item out.
// A byte's pixels start after the next byte of the line is taken, through the job and output registers.
// Throughput: one pixel per clock from the pixel sequencer while m_tready does not stall the output;
// the next byte is taken as the last pixel leaves.
// Reset (rst_n, asynchronous, active low) clears the held byte and all valid flags.
// Depends on hacd_pkg, hacd_line_ctl and hacd_emitter.
module hires_artifact_color_decoder
    import hacd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // column[5:0], data_byte[13:6], zero[15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x[8:0], color_code[11:9], red[19:12],
                                   // green[27:20], blue[35:28], zero[39:36]
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // line_end
);

    job_t        job;
    logic        accept;
    logic        job_ready;
    logic [8:0]  pixel_x;
    color_t      color_code;
    logic [23:0] rgb;

    assign s_tready = job_ready;
    assign accept   = s_tvalid && job_ready;

    // line state and byte release
    hacd_line_ctl u_line_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .column    (s_tdata[5:0]),
        .data_byte (s_tdata[13:6]),
        .job       (job)
    );

    // pixel sequencing and output register
    hacd_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_ready  (job_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pixel_x    (pixel_x),
        .color_code (color_code),
        .rgb        (rgb),
        .run_last   (m_tlast),
        .line_end   (m_tuser)
    );

    // pack the result item
    assign m_tdata = {4'd0, rgb[7:0], rgb[15:8], rgb[23:16], 3'(color_code), pixel_x};

endmodule
